>>> rtl/drfp_pkg.sv
// Package for the display reply frame parser.
// Frame marker bytes, known command codes and the result record.
// No dependencies.
package drfp_pkg;

  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_T  = 8'h54;
  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_E  = 8'h45;

  localparam logic [15:0] CMD_KEY_A = 16'h0002;
  localparam logic [15:0] CMD_KEY_B = 16'h1001;

  localparam int unsigned TAIL_LEN = 5;
  localparam int unsigned TAIL_W   = 3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] command_code;
    logic [7:0]  key_value;
    logic        known_command;
    logic        frame_status;
  } result_t;

endpackage

>>> rtl/display_reply_frame_parser.sv
// channel | handshake          | payload
// rx      | rx_valid, rx_stall | rx_byte
// res     | res_valid, res_stall | kind, payload_byte, command_code, key_value,
//         |                    | known_command, frame_status
//
// One byte per cycle sustained while the result is not stalled; a result passes
// through the input register, then the parser step into the result register.
// Reset (rst, synchronous) returns the parser to hunting for 'S' and empties
// both registers. A stalled result holds the parser and then the input register.
// Top level of the display reply frame parser; depends on drfp_pkg,
// drfp_parser and drfp_out_reg.
module display_reply_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] command_code,
  output logic [7:0]  key_value,
  output logic        known_command,
  output logic        frame_status
);
  import drfp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       step;
  logic       p_valid;
  result_t    p_res;
  result_t    res;

  assign step     = in_valid && out_free;
  assign rx_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!rx_stall) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  drfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .res_valid (p_valid),
    .res       (p_res)
  );

  drfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && p_valid),
    .load_data (p_res),
    .res_stall (res_stall),
    .free      (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign kind          = res.kind;
  assign payload_byte  = res.payload_byte;
  assign command_code  = res.command_code;
  assign key_value     = res.key_value;
  assign known_command = res.known_command;
  assign frame_status  = res.frame_status;

endmodule

>>> rtl/drfp_parser.sv
// Frame parser state machine: consumes one byte per step and forms at most
// one result per byte. Depends on drfp_pkg.
module drfp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output drfp_pkg::result_t res
);
  import drfp_pkg::*;

  typedef enum logic [3:0] {
    HUNT_S  = 4'd0,
    HUNT_T  = 4'd1,
    HUNT_LT = 4'd2,
    CMD_HI  = 4'd3,
    CMD_LO  = 4'd4,
    LEN_HI  = 4'd5,
    LEN_LO  = 4'd6,
    PAYLOAD = 4'd7,
    TAIL    = 4'd8
  } phase_t;

  phase_t              phase, phase_next;
  logic [15:0]         command_reg, command_reg_next;
  logic [15:0]         length_reg, length_reg_next;
  logic [15:0]         byte_count, byte_count_next;
  logic [7:0]          held_key, held_key_next;
  logic [TAIL_W-1:0]   tail_index, tail_index_next;
  logic                tail_good, tail_good_next;
  logic [15:0]         len_full;
  logic                last_payload;
  logic                tail_ok_byte;
  logic [TAIL_W-1:0]   tail_inc;

  assign len_full     = {length_reg[15:8], rx_byte};
  assign last_payload = ({1'b0, byte_count} + 17'd1) == {1'b0, length_reg};
  assign tail_inc     = tail_index + TAIL_W'(1);

  always_comb begin
    unique case (tail_index)
      TAIL_W'(0): tail_ok_byte = (rx_byte == CHAR_GT);
      TAIL_W'(1): tail_ok_byte = (rx_byte == CHAR_E);
      TAIL_W'(2): tail_ok_byte = (rx_byte == CHAR_T);
      default:    tail_ok_byte = 1'b1;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    command_reg_next = command_reg;
    length_reg_next  = length_reg;
    byte_count_next  = byte_count;
    held_key_next    = held_key;
    tail_index_next  = tail_index;
    tail_good_next   = tail_good;
    res_valid        = 1'b0;
    res              = '0;
    unique case (phase)
      HUNT_T: begin
        if (rx_byte == CHAR_T) phase_next = HUNT_LT;
      end
      HUNT_LT: begin
        if (rx_byte == CHAR_LT) phase_next = CMD_HI;
      end
      CMD_HI: begin
        command_reg_next = {rx_byte, 8'h00};
        phase_next       = CMD_LO;
      end
      CMD_LO: begin
        command_reg_next = {command_reg[15:8], rx_byte};
        phase_next       = LEN_HI;
      end
      LEN_HI: begin
        length_reg_next = {rx_byte, 8'h00};
        phase_next      = LEN_LO;
      end
      LEN_LO: begin
        length_reg_next = len_full;
        byte_count_next = '0;
        held_key_next   = '0;
        if (len_full == 16'd0) begin
          phase_next      = TAIL;
          tail_index_next = '0;
          tail_good_next  = 1'b1;
        end else begin
          phase_next = PAYLOAD;
        end
      end
      PAYLOAD: begin
        if (last_payload) begin
          held_key_next   = rx_byte;
          phase_next      = TAIL;
          tail_index_next = '0;
          tail_good_next  = 1'b1;
        end else begin
          byte_count_next  = byte_count + 16'd1;
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end
      TAIL: begin
        tail_good_next  = tail_good & tail_ok_byte;
        tail_index_next = tail_inc;
        if (tail_inc == TAIL_W'(TAIL_LEN)) begin
          res_valid         = 1'b1;
          res.kind          = KIND_FRAME;
          res.command_code  = command_reg;
          res.key_value     = held_key;
          res.known_command = (command_reg == CMD_KEY_A) || (command_reg == CMD_KEY_B);
          res.frame_status  = (tail_good & tail_ok_byte) ? STATUS_GOOD : STATUS_BAD;
          phase_next        = HUNT_S;
          tail_index_next   = '0;
          tail_good_next    = 1'b1;
        end
      end
      default: begin
        phase_next = (rx_byte == CHAR_S) ? HUNT_T : HUNT_S;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= HUNT_S;
      command_reg <= '0;
      length_reg  <= '0;
      byte_count  <= '0;
      held_key    <= '0;
      tail_index  <= '0;
      tail_good   <= 1'b1;
    end else if (step) begin
      phase       <= phase_next;
      command_reg <= command_reg_next;
      length_reg  <= length_reg_next;
      byte_count  <= byte_count_next;
      held_key    <= held_key_next;
      tail_index  <= tail_index_next;
      tail_good   <= tail_good_next;
    end
  end

endmodule

>>> rtl/drfp_out_reg.sv
// Result register: holds one result until the consumer takes it.
// Depends on drfp_pkg.
module drfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  drfp_pkg::result_t load_data,
  input  logic              res_stall,
  output logic              free,
  output logic              res_valid,
  output drfp_pkg::result_t res
);
  import drfp_pkg::*;

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res <= load_data;
    end
  end

endmodule

>>> rtl/drfp_checker.sv
// Port-level checks for the display reply frame parser, bound to the top.
// Depends on drfp_pkg and display_reply_frame_parser.
module drfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic        kind,
  input logic [7:0]  payload_byte,
  input logic [15:0] command_code,
  input logic [7:0]  key_value,
  input logic        known_command,
  input logic        frame_status
);
  import drfp_pkg::*;

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_PAYLOAD |->
      command_code == 16'd0 && key_value == 8'd0 && !known_command && !frame_status)
    else $error("payload transaction carries frame fields");

  a_frame_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_FRAME |-> payload_byte == 8'd0)
    else $error("frame transaction carries a payload byte");

  a_known_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_FRAME |->
      known_command == (command_code == CMD_KEY_A || command_code == CMD_KEY_B))
    else $error("known_command flag disagrees with command_code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(payload_byte)
      && $stable(command_code) && $stable(key_value) && $stable(known_command)
      && $stable(frame_status))
    else $error("stalled result transaction changed");

endmodule

bind display_reply_frame_parser drfp_checker u_drfp_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .kind          (kind),
  .payload_byte  (payload_byte),
  .command_code  (command_code),
  .key_value     (key_value),
  .known_command (known_command),
  .frame_status  (frame_status)
);

>>> verif/display_reply_frame_parser_tb.sv
// Testbench for display_reply_frame_parser: directed and random reply frames, noise and
// broken frames under random input gaps and output stalls, checked by an in-bench parser.
// Depends on drfp_pkg and the display_reply_frame_parser RTL.
module display_reply_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drfp_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 1600;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [3:0] {
    PH_HUNT_S, PH_HUNT_T, PH_HUNT_LT, PH_CMD_HI, PH_CMD_LO,
    PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_TAIL
  } parse_phase_t;

  class frame_ledger;
    parse_phase_t phase;
    logic [15:0]  cmd;
    logic [15:0]  len;
    logic [15:0]  count;
    logic [7:0]   key;
    logic [2:0]   tail_idx;
    logic         tail_ok;
    result_t      due[$];
    int           errors;
    int           payloads;
    int           frames;
    int           bad_frames;

    function new();
      phase      = PH_HUNT_S;
      cmd        = '0;
      len        = '0;
      count      = '0;
      key        = '0;
      tail_idx   = '0;
      tail_ok    = 1'b1;
      errors     = 0;
      payloads   = 0;
      frames     = 0;
      bad_frames = 0;
    endfunction

    function void start_tail();
      phase    = PH_TAIL;
      tail_idx = '0;
      tail_ok  = 1'b1;
    endfunction

    // Advance the parse by one accepted byte and queue any result it causes.
    function void note_byte(logic [7:0] b);
      result_t r;
      r = '0;
      case (phase)
        PH_HUNT_T: if (b == CHAR_T) phase = PH_HUNT_LT;
        PH_HUNT_LT: if (b == CHAR_LT) phase = PH_CMD_HI;
        PH_CMD_HI: begin
          cmd   = {b, 8'h00};
          phase = PH_CMD_LO;
        end
        PH_CMD_LO: begin
          cmd[7:0] = b;
          phase    = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len   = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len[7:0] = b;
          count    = '0;
          key      = '0;
          if (len == 16'd0) start_tail();
          else phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (count + 16'd1 == len) begin
            key = b;
            start_tail();
          end else begin
            count          = count + 16'd1;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            due.push_back(r);
          end
        end
        PH_TAIL: begin
          if ((tail_idx == 3'd0 && b != CHAR_GT) ||
              (tail_idx == 3'd1 && b != CHAR_E) ||
              (tail_idx == 3'd2 && b != CHAR_T))
            tail_ok = 1'b0;
          tail_idx = tail_idx + 3'd1;
          if (int'(tail_idx) == TAIL_LEN) begin
            r.kind          = KIND_FRAME;
            r.command_code  = cmd;
            r.key_value     = key;
            r.known_command = (cmd == CMD_KEY_A) || (cmd == CMD_KEY_B);
            r.frame_status  = tail_ok ? STATUS_GOOD : STATUS_BAD;
            due.push_back(r);
            phase    = PH_HUNT_S;
            tail_idx = '0;
            tail_ok  = 1'b1;
          end
        end
        default: phase = (b == CHAR_S) ? PH_HUNT_T : PH_HUNT_S;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        errors++;
        $error("result with none expected: kind %0d", got.kind);
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind) begin
        errors++;
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
      end
      if (got.payload_byte !== want.payload_byte) begin
        errors++;
        $error("payload_byte: expected %h, got %h", want.payload_byte, got.payload_byte);
      end
      if (got.command_code !== want.command_code) begin
        errors++;
        $error("command_code: expected %h, got %h", want.command_code, got.command_code);
      end
      if (got.key_value !== want.key_value) begin
        errors++;
        $error("key_value: expected %h, got %h", want.key_value, got.key_value);
      end
      if (got.known_command !== want.known_command) begin
        errors++;
        $error("known_command: expected %0d, got %0d", want.known_command,
               got.known_command);
      end
      if (got.frame_status !== want.frame_status) begin
        errors++;
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
      end
      if (want.kind == KIND_FRAME) begin
        frames++;
        if (want.frame_status == STATUS_BAD) bad_frames++;
      end else begin
        payloads++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] command_code;
  logic [7:0]  key_value;
  logic        known_command;
  logic        frame_status;

  frame_ledger ledger;
  logic [7:0]  frame_bytes[$];
  int          sent = 0;
  int          cycles = 0;
  int          stall_hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  display_reply_frame_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .command_code  (command_code),
    .key_value     (key_value),
    .known_command (known_command),
    .frame_status  (frame_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      ledger.check_result({kind, payload_byte, command_code, key_value, known_command,
                           frame_status});
  end

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      res_stall  <= 1'b1;
    end else if (!out_calm && $urandom_range(0, 99) < 3) begin
      stall_hold <= $urandom_range(10, 50);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= !out_calm && ($urandom_range(0, 99) < 25);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    ledger.note_byte(b);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic wait_drained();
    rx_valid <= 1'b0;
    do @(negedge clk); while (ledger.due.size() != 0);
  endtask

  function automatic void push_random(int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void push_word(logic [15:0] w);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endfunction

  // Mostly well-formed frames with random content; some noise and cut-off frames.
  function automatic void build_frame();
    int          sel;
    int          r;
    int          n;
    logic [15:0] cmd;
    logic [15:0] len;
    logic [7:0]  tail[3];
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      push_random($urandom_range(3, 20));
      return;
    end
    push_random($urandom_range(0, 2));
    frame_bytes.push_back(CHAR_S);
    push_random($urandom_range(0, 2));
    frame_bytes.push_back(CHAR_T);
    push_random($urandom_range(0, 1));
    frame_bytes.push_back(CHAR_LT);
    case ($urandom_range(0, 4))
      0: cmd = CMD_KEY_A;
      1: cmd = CMD_KEY_B;
      2: cmd = CMD_KEY_B ^ (16'h0001 << $urandom_range(0, 15));
      default: cmd = 16'($urandom);
    endcase
    r = $urandom_range(0, 99);
    if (r < 70) len = 16'($urandom_range(0, 6));
    else if (r < 99) len = 16'($urandom_range(7, 40));
    else len = 16'($urandom_range(256, 280));
    push_word(cmd);
    push_word(len);
    if (sel < 12) begin
      n = $urandom_range(0, 3);
      push_random((n < int'(len)) ? n : int'(len));
      return;
    end
    push_random(int'(len));
    tail[0] = CHAR_GT;
    tail[1] = CHAR_E;
    tail[2] = CHAR_T;
    if ($urandom_range(0, 99) < 15) tail[$urandom_range(0, 2)] = 8'($urandom);
    foreach (tail[i]) frame_bytes.push_back(tail[i]);
    push_random(2);
  endfunction

  initial begin
    ledger = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Known command, zero length, good tail, after a stray byte.
    frame_bytes = {8'h00, CHAR_S, CHAR_T, CHAR_LT, 8'h00, 8'h02, 8'h00, 8'h00,
                   CHAR_GT, CHAR_E, CHAR_T, 8'hFF, 8'h00};
    send_frame_bytes();
    // Junk between markers, all-ones command, extreme payload bytes, bad tail.
    frame_bytes = {CHAR_S, 8'hFF, CHAR_T, CHAR_LT, 8'hFF, 8'hFF, 8'h00, 8'h02,
                   8'h00, 8'hFF, CHAR_GT, 8'h58, CHAR_T, 8'h00, 8'hFF};
    send_frame_bytes();
    wait_drained();

    while (sent < RANDOM_BYTES) begin
      in_calm  = ($urandom_range(0, 9) == 0);
      out_calm = ($urandom_range(0, 9) == 0);
      build_frame();
      send_frame_bytes();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes; checked %0d payload results and %0d frame results", sent,
             ledger.payloads, ledger.frames);
    $display("(%0d frames with a bad tail), with random gaps and output stalls.",
             ledger.bad_frames);
    if (ledger.errors == 0 && ledger.due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/drfp_pkg.sv
rtl/drfp_parser.sv
rtl/drfp_out_reg.sv
rtl/display_reply_frame_parser.sv
rtl/drfp_checker.sv
verif/display_reply_frame_parser_tb.sv
